// File: design/hpv_pkg.sv
// Package for the host:port endpoint validator.
// Holds the scan state type, status codes and character constants; no dependencies.
`default_nettype none

package hpv_pkg;

  localparam int unsigned MAX_HOST_LEN_DEF  = 253;
  localparam int unsigned MAX_LABEL_LEN_DEF = 63;
  localparam logic [15:0] DEFAULT_PORT_RST  = 16'd28020;

  localparam logic [7:0] HOST_CNT_SAT  = 8'd254;
  localparam logic [7:0] RUN_SAT       = 8'd255;
  localparam logic [6:0] LABEL_SAT     = 7'd127;
  localparam logic [1:0] COLON_SAT     = 2'd2;
  localparam logic [2:0] PART_SAT      = 3'd5;
  localparam logic [2:0] IPV4_DOTS     = 3'd3;
  localparam logic [8:0] OCTET_MAX     = 9'd255;
  localparam logic [8:0] OCTET_SAT     = 9'd256;
  localparam logic [16:0] PORT_MAX     = 17'd65535;
  localparam logic [16:0] PORT_SAT     = 17'd65536;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // port_digits_ok flags
  localparam logic [1:0] PD_DIGIT = 2'b01;
  localparam logic [1:0] PD_OTHER = 2'b10;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_PORT   = 2'd2,
    ST_HOST   = 2'd3
  } status_t;

  typedef struct packed {
    logic        text_started;
    logic        pending_space;
    logic [7:0]  pending_run;
    logic [1:0]  colon_count;
    logic        bracket_seen;
    logic [7:0]  host_count;
    logic        all_numeric;
    logic        dns_ok;
    logic [6:0]  label_count;
    logic        prev_hyphen;
    logic        ipv4_ok;
    logic [8:0]  octet_value;
    logic [2:0]  part_count;
    logic [16:0] port_value;
    logic [1:0]  port_digits_ok;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    text_started:   1'b0,
    pending_space:  1'b0,
    pending_run:    8'd0,
    colon_count:    2'd0,
    bracket_seen:   1'b0,
    host_count:     8'd0,
    all_numeric:    1'b1,
    dns_ok:         1'b1,
    label_count:    7'd0,
    prev_hyphen:    1'b0,
    ipv4_ok:        1'b1,
    octet_value:    9'd0,
    part_count:     3'd0,
    port_value:     17'd0,
    port_digits_ok: 2'b00
  };

  // state after the final byte, handed to the verdict stage
  typedef struct packed {
    logic  valid;
    scan_t state;
  } fin_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

// File: design/hpv_if.sv
// Channel interfaces of the endpoint validator: text bytes, verdicts, config writes.
// Depends on hpv_pkg for the status type.
`default_nettype none

interface hpv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface hpv_result_if;
  logic                 valid;
  logic                 ready;
  hpv_pkg::status_t     status;
  logic [15:0]          port_number;
  logic                 host_is_ipv4;
  logic [7:0]           host_length;
  modport source (output valid, output status, output port_number, output host_is_ipv4,
                  output host_length, input ready);
  modport sink   (input valid, input status, input port_number, input host_is_ipv4,
                  input host_length, output ready);
endinterface

interface hpv_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/hpv_scan.sv
// Input beat register and per-byte scan state of the endpoint validator.
// Depends on hpv_pkg and hpv_char_if.
`default_nettype none

module hpv_scan #(
  parameter int unsigned MAX_LABEL_LEN = hpv_pkg::MAX_LABEL_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  hpv_char_if.sink           text,
  output hpv_pkg::fin_t      fin,
  input  wire logic          fin_ready
);

  logic           beat_valid;
  logic [7:0]     beat_char;
  logic           beat_last;
  hpv_pkg::scan_t state;
  hpv_pkg::scan_t state_next;
  logic           retire;
  logic [11:0]    oct_mul;
  logic [20:0]    port_mul;
  logic [8:0]     host_sum;

  assign retire     = beat_valid && (!beat_last || fin_ready);
  assign text.ready = !beat_valid || retire;

  assign oct_mul  = {3'b000, state.octet_value} * 12'd10 + {8'd0, beat_char[3:0]};
  assign port_mul = {4'd0, state.port_value} * 21'd10 + {17'd0, beat_char[3:0]};
  assign host_sum = {1'b0, state.host_count} + {1'b0, state.pending_run};

  always_comb begin
    state_next = state;
    if (hpv_pkg::is_ws(beat_char)) begin
      if (state.text_started) begin
        state_next.pending_space = 1'b1;
        if (state.pending_run < hpv_pkg::RUN_SAT) begin
          state_next.pending_run = state.pending_run + 8'd1;
        end
      end
    end else begin
      state_next.text_started = 1'b1;
      // held whitespace turns into interior bytes
      if (state.pending_space) begin
        if (state.colon_count == 2'd0) begin
          state_next.host_count  = (host_sum > {1'b0, hpv_pkg::HOST_CNT_SAT}) ?
                                   hpv_pkg::HOST_CNT_SAT : host_sum[7:0];
          state_next.all_numeric = 1'b0;
          state_next.dns_ok      = 1'b0;
          state_next.prev_hyphen = 1'b0;
          if (state_next.label_count < hpv_pkg::LABEL_SAT) begin
            state_next.label_count = state_next.label_count + 7'd1;
          end
        end else if (state.colon_count == 2'd1) begin
          state_next.port_digits_ok = state_next.port_digits_ok | hpv_pkg::PD_OTHER;
        end
        state_next.pending_space = 1'b0;
        state_next.pending_run   = 8'd0;
      end
      if (beat_char == hpv_pkg::CH_LBRACK || beat_char == hpv_pkg::CH_RBRACK) begin
        state_next.bracket_seen = 1'b1;
      end
      if (beat_char == hpv_pkg::CH_COLON) begin
        if (state.colon_count < hpv_pkg::COLON_SAT) begin
          state_next.colon_count = state.colon_count + 2'd1;
        end
      end else if (state.colon_count == 2'd0) begin
        if (state_next.host_count < hpv_pkg::HOST_CNT_SAT) begin
          state_next.host_count = state_next.host_count + 8'd1;
        end
        if (beat_char == hpv_pkg::CH_DOT) begin
          if (state_next.label_count == 7'd0 || state.octet_value > hpv_pkg::OCTET_MAX) begin
            state_next.ipv4_ok = 1'b0;
          end
          if (state_next.label_count == 7'd0 || state_next.prev_hyphen) begin
            state_next.dns_ok = 1'b0;
          end
          if (state.part_count < hpv_pkg::PART_SAT) begin
            state_next.part_count = state.part_count + 3'd1;
          end
          state_next.octet_value = 9'd0;
          state_next.label_count = 7'd0;
          state_next.prev_hyphen = 1'b0;
        end else begin
          if (hpv_pkg::is_digit(beat_char)) begin
            state_next.octet_value = (oct_mul > {3'b000, hpv_pkg::OCTET_SAT}) ?
                                     hpv_pkg::OCTET_SAT : oct_mul[8:0];
          end else begin
            state_next.all_numeric = 1'b0;
          end
          if (beat_char == hpv_pkg::CH_HYPHEN) begin
            if (state_next.label_count == 7'd0) state_next.dns_ok = 1'b0;
          end else if (!hpv_pkg::is_alnum(beat_char)) begin
            state_next.dns_ok = 1'b0;
          end
          state_next.prev_hyphen = (beat_char == hpv_pkg::CH_HYPHEN);
          if (state_next.label_count >= 7'(MAX_LABEL_LEN)) state_next.dns_ok = 1'b0;
          if (state_next.label_count < hpv_pkg::LABEL_SAT) begin
            state_next.label_count = state_next.label_count + 7'd1;
          end
        end
      end else if (state.colon_count == 2'd1) begin
        if (hpv_pkg::is_digit(beat_char)) begin
          state_next.port_digits_ok = state_next.port_digits_ok | hpv_pkg::PD_DIGIT;
          state_next.port_value     = (port_mul > {4'd0, hpv_pkg::PORT_SAT}) ?
                                      hpv_pkg::PORT_SAT : port_mul[16:0];
        end else begin
          state_next.port_digits_ok = state_next.port_digits_ok | hpv_pkg::PD_OTHER;
        end
      end
    end
  end

  assign fin = '{valid: beat_valid && beat_last, state: state_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
      state      <= hpv_pkg::SCAN_RESET;
    end else begin
      if (text.valid && text.ready) begin
        beat_valid <= 1'b1;
      end else if (retire) begin
        beat_valid <= 1'b0;
      end
      if (retire) state <= beat_last ? hpv_pkg::SCAN_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      beat_char <= text.character;
      beat_last <= text.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    retire && beat_last |=> state == hpv_pkg::SCAN_RESET)
    else $error("scan state not cleared after final beat");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    beat_valid && !retire |=> beat_valid && $stable(state))
    else $error("scan state moved while final beat stalled");
  a_counters_sat: assert property (@(posedge clk) disable iff (rst)
    state.colon_count <= hpv_pkg::COLON_SAT && state.host_count <= hpv_pkg::HOST_CNT_SAT &&
    state.part_count <= hpv_pkg::PART_SAT)
    else $error("scan counter past saturation");
`endif

endmodule

`default_nettype wire

// File: design/hpv_verdict.sv
// Verdict logic, default port register and result register of the endpoint validator.
// Depends on hpv_pkg, hpv_result_if and hpv_cfg_if.
`default_nettype none

module hpv_verdict #(
  parameter int unsigned MAX_HOST_LEN = hpv_pkg::MAX_HOST_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hpv_pkg::fin_t fin,
  output logic               fin_ready,
  hpv_result_if.source       result,
  hpv_cfg_if.sink            cfg
);

  logic             out_valid;
  logic [15:0]      default_port;
  logic             host_good;
  hpv_pkg::status_t status_next;
  logic [15:0]      port_next;
  logic             ipv4_next;
  hpv_pkg::scan_t   s;

  assign s          = fin.state;
  assign fin_ready  = !out_valid || result.ready;
  assign cfg.ready  = 1'b1;
  assign result.valid = out_valid;

  always_comb begin
    if (s.all_numeric) begin
      host_good = s.ipv4_ok && (s.label_count != 7'd0) && (s.octet_value <= hpv_pkg::OCTET_MAX)
                  && (s.part_count == hpv_pkg::IPV4_DOTS);
    end else begin
      host_good = s.dns_ok && (s.label_count != 7'd0) && !s.prev_hyphen;
    end
    if (s.host_count == 8'd0 || s.host_count > 8'(MAX_HOST_LEN)) host_good = 1'b0;

    port_next = 16'd0;
    ipv4_next = 1'b0;
    if (!s.text_started || s.bracket_seen || s.colon_count >= hpv_pkg::COLON_SAT) begin
      status_next = hpv_pkg::ST_FORMAT;
    end else if (s.colon_count == 2'd1 && (s.port_digits_ok != hpv_pkg::PD_DIGIT ||
               s.port_value == 17'd0 || s.port_value > hpv_pkg::PORT_MAX)) begin
      status_next = hpv_pkg::ST_PORT;
    end else begin
      ipv4_next = s.all_numeric;
      if (host_good) begin
        status_next = hpv_pkg::ST_OK;
        port_next   = (s.colon_count == 2'd1) ? s.port_value[15:0] : default_port;
      end else begin
        status_next = hpv_pkg::ST_HOST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      default_port <= hpv_pkg::DEFAULT_PORT_RST;
    end else begin
      if (fin.valid && fin_ready) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) default_port <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid && fin_ready) begin
      result.status       <= status_next;
      result.port_number  <= port_next;
      result.host_is_ipv4 <= ipv4_next;
      result.host_length  <= s.host_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_port_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status != hpv_pkg::ST_OK |-> result.port_number == 16'd0)
    else $error("port reported on a failed verdict");
  a_ipv4_only_on_host_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.status == hpv_pkg::ST_FORMAT || result.status == hpv_pkg::ST_PORT)
    |-> !result.host_is_ipv4)
    else $error("ipv4 flag set on format or port error");
  a_fin_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    fin.valid && !fin_ready |-> out_valid)
    else $error("final beat stalled with empty result register");
`endif

endmodule

`default_nettype wire

// File: design/host_port_endpoint_validator.sv
// Endpoint validator top level: one text byte per beat, one verdict per final byte.
// A verdict is registered in the result register when its final beat leaves the input register.
// Throughput: one byte per cycle; the input register and result register decouple
// the two sides, so a held verdict stalls input only once the final byte is waiting.
// Reset (synchronous, rst high) empties both registers, clears the scan state and
// loads default_port with 28020. Depends on hpv_pkg, hpv_if, hpv_scan, hpv_verdict.
`default_nettype none

module host_port_endpoint_validator #(
  parameter int unsigned MAX_HOST_LEN  = hpv_pkg::MAX_HOST_LEN_DEF,
  parameter int unsigned MAX_LABEL_LEN = hpv_pkg::MAX_LABEL_LEN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  hpv_char_if.sink      text,
  hpv_result_if.source  result,
  hpv_cfg_if.sink       cfg
);

  hpv_pkg::fin_t fin;
  logic          fin_ready;

  hpv_scan #(
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  hpv_verdict #(
    .MAX_HOST_LEN (MAX_HOST_LEN)
  ) u_verdict (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .fin_ready (fin_ready),
    .result    (result),
    .cfg       (cfg)
  );

endmodule

`default_nettype wire

// File: verif/host_port_endpoint_validator_test.sv
// Self-checking bench for host_port_endpoint_validator: byte beats of endpoint texts in,
// one verdict per final beat out, checked against an in-bench scan predictor.
// Depends on hpv_pkg, hpv_if and the design files.
`default_nettype none

module host_port_endpoint_validator_test;

  localparam int unsigned HOST_LIMIT  = hpv_pkg::MAX_HOST_LEN_DEF;
  localparam int unsigned LABEL_LIMIT = hpv_pkg::MAX_LABEL_LEN_DEF;
  localparam int          TOTAL_BEATS = 1550;
  localparam string       ALNUM_SET   =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  localparam string       HOT_SET     = " \t\r\n:.-[]0a9Z";

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } text_beat_t;

  typedef struct {
    hpv_pkg::status_t status;
    logic [15:0]      port;
    logic             ipv4;
    logic [7:0]       host_len;
  } verdict_t;

  logic clk;
  logic rst;

  hpv_char_if   text_ch();
  hpv_result_if verdict_ch();
  hpv_cfg_if    cfg_ch();

  host_port_endpoint_validator dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (verdict_ch),
    .cfg    (cfg_ch)
  );

  text_beat_t  pending_beats[$];
  verdict_t    expected_verdicts[$];
  logic [7:0]  draft[$];
  int          queued_beats;
  int          accepted_beats;
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          run_phase;
  logic        rx_hold;

  // predictor copy of the register and scan state
  logic [15:0] port_default;
  logic        seen_text;
  logic        ws_held;
  logic [7:0]  ws_run;
  logic [1:0]  colons;
  logic        has_bracket;
  logic [7:0]  host_len;
  logic        digits_only;
  logic        name_ok;
  logic [6:0]  label_len;
  logic        last_was_hyphen;
  logic        quad_ok;
  logic [8:0]  octet;
  logic [2:0]  dots;
  logic [16:0] port_acc;
  logic [1:0]  port_flags;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == hpv_pkg::CH_SPACE || c == hpv_pkg::CH_TAB || c == hpv_pkg::CH_CR ||
           c == hpv_pkg::CH_LF;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_num(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_scan();
    seen_text       = 1'b0;
    ws_held         = 1'b0;
    ws_run          = '0;
    colons          = '0;
    has_bracket     = 1'b0;
    host_len        = '0;
    digits_only     = 1'b1;
    name_ok         = 1'b1;
    label_len       = '0;
    last_was_hyphen = 1'b0;
    quad_ok         = 1'b1;
    octet           = '0;
    dots            = '0;
    port_acc        = '0;
    port_flags      = '0;
  endfunction

  function automatic void grow_label();
    if (label_len >= LABEL_LIMIT) name_ok = 1'b0;
    if (label_len < hpv_pkg::LABEL_SAT) label_len = label_len + 1'b1;
  endfunction

  function automatic void host_char(input logic [7:0] c);
    int acc;
    if (host_len < hpv_pkg::HOST_CNT_SAT) host_len = host_len + 1'b1;
    if (c == hpv_pkg::CH_DOT) begin
      if (label_len == 0 || octet > hpv_pkg::OCTET_MAX) quad_ok = 1'b0;
      if (label_len == 0 || last_was_hyphen) name_ok = 1'b0;
      if (dots < hpv_pkg::PART_SAT) dots = dots + 1'b1;
      octet = '0;
      label_len = '0;
      last_was_hyphen = 1'b0;
      return;
    end
    if (is_num(c)) begin
      acc = octet * 10 + (c - 8'h30);
      octet = (acc > hpv_pkg::OCTET_SAT) ? hpv_pkg::OCTET_SAT : acc[8:0];
    end else begin
      digits_only = 1'b0;
    end
    if (c == hpv_pkg::CH_HYPHEN) begin
      if (label_len == 0) name_ok = 1'b0;
    end else if (!is_word_char(c)) begin
      name_ok = 1'b0;
    end
    last_was_hyphen = (c == hpv_pkg::CH_HYPHEN);
    grow_label();
  endfunction

  function automatic void port_char(input logic [7:0] c);
    int acc;
    if (is_num(c)) begin
      port_flags = port_flags | hpv_pkg::PD_DIGIT;
      acc = port_acc * 10 + (c - 8'h30);
      port_acc = (acc > hpv_pkg::PORT_SAT) ? hpv_pkg::PORT_SAT : acc[16:0];
    end else begin
      port_flags = port_flags | hpv_pkg::PD_OTHER;
    end
  endfunction

  function automatic void absorb_held_ws();
    int acc;
    if (!ws_held) return;
    if (colons == 0) begin
      acc = host_len + ws_run;
      host_len = (acc > hpv_pkg::HOST_CNT_SAT) ? hpv_pkg::HOST_CNT_SAT : acc[7:0];
      digits_only = 1'b0;
      name_ok = 1'b0;
      last_was_hyphen = 1'b0;
      grow_label();
    end else if (colons == 1) begin
      port_flags = port_flags | hpv_pkg::PD_OTHER;
    end
    ws_held = 1'b0;
    ws_run = '0;
  endfunction

  function automatic void scan_beat(input logic [7:0] c, input logic is_last);
    verdict_t v;
    logic     good;
    if (is_blank(c)) begin
      if (seen_text) begin
        ws_held = 1'b1;
        if (ws_run < hpv_pkg::RUN_SAT) ws_run = ws_run + 1'b1;
      end
    end else begin
      seen_text = 1'b1;
      absorb_held_ws();
      if (c == hpv_pkg::CH_LBRACK || c == hpv_pkg::CH_RBRACK) has_bracket = 1'b1;
      if (c == hpv_pkg::CH_COLON) begin
        if (colons < hpv_pkg::COLON_SAT) colons = colons + 1'b1;
      end else if (colons == 0) begin
        host_char(c);
      end else if (colons == 1) begin
        port_char(c);
      end
    end
    if (!is_last) return;
    if (digits_only) begin
      good = quad_ok && label_len != 0 && octet <= hpv_pkg::OCTET_MAX &&
             dots == hpv_pkg::IPV4_DOTS;
    end else begin
      good = name_ok && label_len != 0 && !last_was_hyphen;
    end
    if (host_len == 0 || host_len > HOST_LIMIT) good = 1'b0;
    v.port = '0;
    v.ipv4 = 1'b0;
    v.host_len = host_len;
    if (!seen_text || has_bracket || colons >= hpv_pkg::COLON_SAT) begin
      v.status = hpv_pkg::ST_FORMAT;
    end else if (colons == 1 && (port_flags != hpv_pkg::PD_DIGIT || port_acc == 0 ||
                                 port_acc > hpv_pkg::PORT_MAX)) begin
      v.status = hpv_pkg::ST_PORT;
    end else begin
      v.ipv4 = digits_only;
      if (good) begin
        v.status = hpv_pkg::ST_OK;
        v.port = (colons == 1) ? port_acc[15:0] : port_default;
      end else begin
        v.status = hpv_pkg::ST_HOST;
      end
    end
    expected_verdicts = {expected_verdicts, v};
    clear_scan();
  endfunction

  // text builders
  function automatic void add_char(input logic [7:0] c);
    draft = {draft, c};
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 3))
      0: return hpv_pkg::CH_SPACE;
      1: return hpv_pkg::CH_TAB;
      2: return hpv_pkg::CH_CR;
      default: return hpv_pkg::CH_LF;
    endcase
  endfunction

  function automatic void add_ws_run(input int n);
    for (int i = 0; i < n; i++) add_char(rand_ws());
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ALNUM_SET[$urandom_range(0, ALNUM_SET.len() - 1)];
  endfunction

  function automatic void flush_draft();
    text_beat_t b;
    for (int i = 0; i < draft.size(); i++) begin
      b.ch      = draft[i];
      b.is_last = (i == draft.size() - 1);
      pending_beats = {pending_beats, b};
    end
    queued_beats += draft.size();
    draft.delete();
  endfunction

  function automatic void add_octet();
    case ($urandom_range(0, 9))
      7: add_str($sformatf("%0d", $urandom_range(256, 999)));
      8: add_str($sformatf("0%0d", $urandom_range(0, 99)));
      9: ;
      default: add_str($sformatf("%0d", $urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void add_ipv4();
    int r;
    int parts;
    r = $urandom_range(0, 99);
    parts = (r < 85) ? 4 : (r < 92) ? 3 : 5;
    for (int i = 0; i < parts; i++) begin
      if (i > 0) add_char(hpv_pkg::CH_DOT);
      add_octet();
    end
  endfunction

  function automatic void add_label(input int len, input logic clean);
    int base;
    base = draft.size();
    for (int i = 0; i < len; i++) begin
      if (i == 0 || i == len - 1 || $urandom_range(0, 5) != 0) add_char(rand_alnum());
      else add_char(hpv_pkg::CH_HYPHEN);
    end
    if (!clean) begin
      case ($urandom_range(0, 2))
        0: draft[base + $urandom_range(0, len - 1)] = hpv_pkg::CH_HYPHEN;
        1: draft[base + $urandom_range(0, len - 1)] = "_";
        default: draft[base + $urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      endcase
    end
  endfunction

  function automatic void add_dns();
    int nlab;
    int r;
    int len;
    nlab = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) add_char(hpv_pkg::CH_DOT);
    for (int i = 0; i < nlab; i++) begin
      if (i > 0) add_char(hpv_pkg::CH_DOT);
      if ($urandom_range(0, 29) == 0) add_char(hpv_pkg::CH_DOT);
      r = $urandom_range(0, 19);
      len = (r == 0) ? LABEL_LIMIT : (r == 1) ? LABEL_LIMIT + 1 : $urandom_range(1, 10);
      add_label(len, $urandom_range(0, 9) != 0);
    end
    if ($urandom_range(0, 19) == 0) add_char(hpv_pkg::CH_DOT);
  endfunction

  function automatic void add_long_host();
    int base;
    int target;
    int n;
    base = draft.size();
    target = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(250, 256);
    while (draft.size() - base < target) begin
      if (draft.size() > base) add_char(hpv_pkg::CH_DOT);
      n = target - (draft.size() - base);
      if (n > LABEL_LIMIT) n = LABEL_LIMIT;
      if (n < 1) n = 1;
      add_label(n, 1'b1);
    end
  endfunction

  function automatic void add_port();
    add_char(hpv_pkg::CH_COLON);
    case ($urandom_range(0, 9))
      5: begin
        case ($urandom_range(0, 4))
          0: add_str("0");
          1: add_str("65535");
          2: add_str("65536");
          3: add_str("1");
          default: add_str("99999999");
        endcase
      end
      6: add_str($sformatf("000%0d", $urandom_range(1, 65535)));
      7: ;
      8: begin
        add_str($sformatf("%0d", $urandom_range(1, 999)));
        add_char(8'($urandom_range(0, 255)));
        add_str($sformatf("%0d", $urandom_range(0, 99)));
      end
      9: begin
        add_str($sformatf("%0d", $urandom_range(1, 999)));
        add_ws_run($urandom_range(1, 2));
        add_str($sformatf("%0d", $urandom_range(0, 99)));
      end
      default: add_str($sformatf("%0d", $urandom_range(1, 65535)));
    endcase
  endfunction

  function automatic void compose_text();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) == 0) add_char(8'($urandom_range(0, 255)));
        else add_char(HOT_SET[$urandom_range(0, HOT_SET.len() - 1)]);
      end
    end else begin
      if ($urandom_range(0, 9) < 3) add_ws_run($urandom_range(1, 3));
      if ($urandom_range(0, 32) == 0) add_char(hpv_pkg::CH_LBRACK);
      r = $urandom_range(0, 99);
      if (r < 45) add_ipv4();
      else if (r < 94) add_dns();
      else add_long_host();
      if ($urandom_range(0, 19) == 0) begin
        add_ws_run($urandom_range(1, 3));
        add_char(rand_alnum());
      end
      if ($urandom_range(0, 9) < 6) add_port();
      if ($urandom_range(0, 32) == 0) begin
        add_char(hpv_pkg::CH_COLON);
        add_str($sformatf("%0d", $urandom_range(1, 999)));
      end
      if ($urandom_range(0, 9) < 3) add_ws_run($urandom_range(1, 3));
    end
    flush_draft();
  endfunction

  task automatic wait_drained();
    while (accepted_beats != queued_beats || expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default_port(input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    port_default = value;
  endtask

  // text beat driver
  always @(posedge clk) begin : drive_text
    text_beat_t next_beat;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        accepted_beats++;
        scan_beat(text_ch.character, text_ch.last);
      end
      if (!text_ch.valid || text_ch.ready) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          text_ch.valid     <= 1'b1;
          text_ch.character <= next_beat.ch;
          text_ch.last      <= next_beat.is_last;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin : watch_verdicts
    verdict_t want;
    if (rst) begin
      verdict_ch.ready <= 1'b0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict beat with none outstanding");
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, verdict_ch.status);
            error_count++;
          end
          if (verdict_ch.port_number !== want.port) begin
            $error("port_number: expected %0d, got %0d", want.port, verdict_ch.port_number);
            error_count++;
          end
          if (verdict_ch.host_is_ipv4 !== want.ipv4) begin
            $error("host_is_ipv4: expected %0d, got %0d", want.ipv4, verdict_ch.host_is_ipv4);
            error_count++;
          end
          if (verdict_ch.host_length !== want.host_len) begin
            $error("host_length: expected %0d, got %0d", want.host_len,
                   verdict_ch.host_length);
            error_count++;
          end
        end
      end
      verdict_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin : rx_long_hold
    rx_hold = 1'b0;
    wait (run_phase == 3);
    repeat (16) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    int goal;
    int base;
    text_ch.valid     = 1'b0;
    text_ch.character = '0;
    text_ch.last      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    verdict_ch.ready  = 1'b0;
    queued_beats      = 0;
    accepted_beats    = 0;
    error_count       = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    run_phase         = 0;
    port_default      = hpv_pkg::DEFAULT_PORT_RST;
    clear_scan();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed texts under the reset default port
    add_str("1.2.3.4");                       flush_draft();
    add_str("255.255.255.255:65535");         flush_draft();
    add_str("256.1.1.1:80");                  flush_draft();
    add_str("1.2.3");                         flush_draft();
    add_str("example.com:1");                 flush_draft();
    add_str(" \t host-a.b \r\n");             flush_draft();
    add_str(" \t\r\n");                       flush_draft();
    add_str("a b:80");                        flush_draft();
    add_str("h:8 0");                         flush_draft();
    add_str("[::1]:80");                      flush_draft();
    add_str("a:1:2");                         flush_draft();
    add_str("h:65536");                       flush_draft();
    add_str("h:0");                           flush_draft();
    add_str("h:");                            flush_draft();
    add_str(":80");                           flush_draft();
    add_str("-a.com");                        flush_draft();
    add_str("a-.com");                        flush_draft();
    add_str("a..b");                          flush_draft();
    add_str("h:00080");                       flush_draft();
    add_str("ab"); add_char(8'hFF); add_str(".c"); flush_draft();
    add_char(8'h00);                          flush_draft();
    wait_drained();

    base = queued_beats;
    for (int p = 1; p <= 4; p++) begin
      case (p)
        1: begin send_idle_pct = 32; recv_idle_pct = 75; write_default_port(16'hFFFF); end
        2: begin send_idle_pct = 75; recv_idle_pct = 32; write_default_port(16'd1); end
        3: begin send_idle_pct = 0;  recv_idle_pct = 0;  write_default_port(16'd0); end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_default_port(16'($urandom_range(1, 65535)));
        end
      endcase
      goal = base + (TOTAL_BEATS - base) * p / 4;
      run_phase = p;
      while (queued_beats < goal) compose_text();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// File: host_port_endpoint_validator.f
design/hpv_pkg.sv
design/hpv_if.sv
design/hpv_scan.sv
design/hpv_verdict.sv
design/host_port_endpoint_validator.sv
verif/host_port_endpoint_validator_test.sv
